@@ design/kcl_pkg.sv @@
// kcl_pkg: shared types, codes and constants for the keypad code lock.
// No dependencies; every other design file imports it.
package kcl_pkg;

  localparam int KEY_W    = 5;
  localparam int DIGIT_W  = 4;
  localparam int PERIOD_W = 16;
  localparam int LED_W    = 8;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [PERIOD_W-1:0] TICK_MAX         = '1;
  localparam logic [PERIOD_W-1:0] FLOW_PERIOD_RST  = PERIOD_W'(200);
  localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST = PERIOD_W'(300);
  localparam logic [LED_W-1:0]    PATTERN_RST      = 8'hFE;
  localparam logic [LED_W-1:0]    PORT_OFF         = 8'hFF;

  // key codes (after edge detection)
  localparam logic [KEY_W-1:0] KEY_NONE   = KEY_W'(0);
  localparam logic [KEY_W-1:0] KEY_ZERO   = KEY_W'(10);
  localparam logic [KEY_W-1:0] KEY_CHECK  = KEY_W'(11);
  localparam logic [KEY_W-1:0] KEY_CLEAR  = KEY_W'(12);
  localparam logic [KEY_W-1:0] KEY_CHANGE = KEY_W'(16);

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SCAN = 1'b1
  } kcl_op_e;

  typedef enum logic [1:0] {
    PH_ENTER = 2'd0,
    PH_OPEN  = 2'd1,
    PH_WRONG = 2'd2
  } kcl_phase_e;

  typedef enum logic [1:0] {
    LM_OFF   = 2'd0,
    LM_FLOW  = 2'd1,
    LM_BLINK = 2'd2
  } kcl_light_e;

  typedef enum logic [1:0] {
    NT_NONE    = 2'd0,
    NT_SAVED   = 2'd1,
    NT_REFUSED = 2'd2
  } kcl_notice_e;

  // register index (byte address bit 2)
  typedef enum logic {
    REG_FLOW  = 1'b0,
    REG_BLINK = 1'b1
  } kcl_reg_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] flow_period;
    logic [PERIOD_W-1:0] blink_period;
  } kcl_cfg_t;

  typedef struct packed {
    kcl_op_e            opcode;
    logic [KEY_W-1:0]   key_number;
  } kcl_item_t;

  typedef struct packed {
    logic       set;
    kcl_light_e mode;
  } kcl_light_cmd_t;

  typedef struct packed {
    kcl_phase_e  phase;
    logic        change;
    logic [2:0]  digits;
    kcl_notice_e notice;
    logic        refresh;
  } kcl_status_t;

  // factory code: 1,2,3,... modulo 16
  function automatic logic [DIGIT_W-1:0] code_rst(input int idx);
    return DIGIT_W'(idx + 1);
  endfunction

endpackage

@@ design/kcl_if.sv @@
// kcl_if: valid/ready channel interfaces for input items and results.
// Depends on kcl_pkg for field widths.
interface kcl_in_if import kcl_pkg::*;;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [KEY_W-1:0] key_number;

  modport source (output valid, opcode, key_number, input ready);
  modport sink   (input valid, opcode, key_number, output ready);
endinterface

interface kcl_out_if import kcl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [LED_W-1:0] led_port;
  logic [1:0]       lock_status;
  logic             setting_active;
  logic [2:0]       digits_entered;
  logic [1:0]       notice;
  logic             display_refresh;

  modport source (output valid, led_port, lock_status, setting_active, digits_entered,
                  notice, display_refresh, input ready);
  modport sink   (input valid, led_port, lock_status, setting_active, digits_entered,
                  notice, display_refresh, output ready);
endinterface

@@ design/kcl_apb_regs.sv @@
// kcl_apb_regs: APB register file holding the flow and blink periods.
// Depends on kcl_pkg.
module kcl_apb_regs import kcl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output kcl_cfg_t          cfg_o
);

  kcl_cfg_t cfg_q, cfg_d;
  kcl_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = kcl_reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_FLOW:  cfg_d.flow_period  = pwdata[PERIOD_W-1:0];
        REG_BLINK: cfg_d.blink_period = pwdata[PERIOD_W-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FLOW:  prdata = APB_DW'(cfg_q.flow_period);
      REG_BLINK: prdata = APB_DW'(cfg_q.blink_period);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.flow_period  <= FLOW_PERIOD_RST;
      cfg_q.blink_period <= BLINK_PERIOD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/kcl_entry.sv @@
// kcl_entry: key edge detection, digit entry, code check and code change.
// Depends on kcl_pkg; drives light commands into kcl_light.
module kcl_entry import kcl_pkg::*; #(
  parameter int CODE_DIGITS = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  kcl_item_t      item_i,
  output kcl_light_cmd_t cmd_o,
  output kcl_status_t    status_o
);

  localparam int CNT_W = $clog2(CODE_DIGITS + 1);
  localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_DIGITS);

  logic [DIGIT_W-1:0] stored_q [CODE_DIGITS];
  logic [DIGIT_W-1:0] entry_q  [CODE_DIGITS];
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  kcl_phase_e         phase_q, phase_d;
  logic               change_q, change_d;
  logic [KEY_W-1:0]   last_key_q, last_key_d;

  logic               scan;
  logic [KEY_W-1:0]   key_edge;
  logic               match;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_idx;
  logic [DIGIT_W-1:0] wr_digit;
  logic               save;
  kcl_notice_e        notice;
  logic [CNT_W+2:0]   cnt_ext;

  assign scan     = (item_i.opcode == OP_SCAN);
  assign key_edge = item_i.key_number & (last_key_q ^ item_i.key_number);
  assign wr_digit = (key_edge == KEY_ZERO) ? '0 : key_edge[DIGIT_W-1:0];

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (entry_q[i] != stored_q[i]) match = 1'b0;
    end
  end

  // next state
  always_comb begin
    cnt_d      = cnt_q;
    phase_d    = phase_q;
    change_d   = change_q;
    last_key_d = scan ? item_i.key_number : last_key_q;
    cmd_o      = '{set: 1'b0, mode: LM_OFF};
    notice     = NT_NONE;
    wr_en      = 1'b0;
    wr_idx     = cnt_q[IDX_W-1:0];
    save       = 1'b0;
    if (scan && key_edge != KEY_NONE) begin
      priority if (key_edge <= KEY_ZERO && cnt_q < CNT_FULL) begin
        wr_en = 1'b1;
        if (!change_q && phase_q != PH_ENTER) begin
          // first digit after a check restarts the buffer
          wr_idx  = '0;
          cnt_d   = CNT_W'(1);
          phase_d = PH_ENTER;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end else if (key_edge == KEY_CHECK) begin
        if (!change_q && cnt_q == CNT_FULL) begin
          cmd_o.set = 1'b1;
          if (match) begin
            phase_d    = PH_OPEN;
            cmd_o.mode = LM_FLOW;
          end else begin
            phase_d    = PH_WRONG;
            cmd_o.mode = LM_BLINK;
          end
        end
      end else if (key_edge == KEY_CLEAR) begin
        cnt_d      = '0;
        phase_d    = PH_ENTER;
        change_d   = 1'b0;
        cmd_o.set  = 1'b1;
        cmd_o.mode = LM_OFF;
      end else if (key_edge == KEY_CHANGE) begin
        if (phase_q == PH_OPEN) begin
          if (!change_q) begin
            change_d = 1'b1;
            cnt_d    = '0;
          end else if (cnt_q == CNT_FULL) begin
            save       = 1'b1;
            change_d   = 1'b0;
            phase_d    = PH_ENTER;
            cnt_d      = '0;
            cmd_o.set  = 1'b1;
            cmd_o.mode = LM_OFF;
            notice     = NT_SAVED;
          end
        end else begin
          notice = NT_REFUSED;
        end
      end else begin
        // digit into a full buffer or an unused key: refresh only
      end
    end
  end

  // outputs
  always_comb begin
    cnt_ext            = {3'b000, cnt_d};
    status_o.phase     = phase_d;
    status_o.change    = change_d;
    status_o.digits    = cnt_ext[2:0];
    status_o.notice    = notice;
    status_o.refresh   = scan && (key_edge != KEY_NONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      phase_q    <= PH_ENTER;
      change_q   <= 1'b0;
      last_key_q <= '0;
    end else if (step_i) begin
      cnt_q      <= cnt_d;
      phase_q    <= phase_d;
      change_q   <= change_d;
      last_key_q <= last_key_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CODE_DIGITS; i++) stored_q[i] <= code_rst(i);
    end else if (step_i && save) begin
      for (int i = 0; i < CODE_DIGITS; i++) stored_q[i] <= entry_q[i];
    end
  end

  // entry buffer: contents are only read once the count says they are written
  always_ff @(posedge clk_i) begin
    if (step_i && wr_en) entry_q[wr_idx] <= wr_digit;
  end

endmodule

@@ design/kcl_light.sv @@
// kcl_light: LED driver with the running light, the blink mode and the tick counter.
// Depends on kcl_pkg; commanded by kcl_entry, periods from kcl_apb_regs.
module kcl_light import kcl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             tick_i,
  input  kcl_light_cmd_t   cmd_i,
  input  kcl_cfg_t         cfg_i,
  output logic [LED_W-1:0] led_o
);

  kcl_light_e          mode_q, mode_d;
  logic [PERIOD_W-1:0] tick_q, tick_d, tick_inc;
  logic [LED_W-1:0]    pat_q, pat_d;
  logic [LED_W-1:0]    port_q, port_d;

  assign tick_inc = (tick_i && tick_q != TICK_MAX) ? tick_q + PERIOD_W'(1) : tick_q;
  assign mode_d   = cmd_i.set ? cmd_i.mode : mode_q;

  // next state
  always_comb begin
    tick_d = tick_inc;
    pat_d  = pat_q;
    port_d = port_q;
    unique case (mode_d)
      LM_FLOW: begin
        if (tick_inc >= cfg_i.flow_period) begin
          tick_d = '0;
          pat_d  = {pat_q[0], pat_q[LED_W-1:1]};
          port_d = pat_d;
        end
      end
      LM_BLINK: begin
        if (tick_inc >= cfg_i.blink_period) begin
          tick_d = '0;
          port_d = ~port_q;
        end
      end
      default: begin
        tick_d = '0;
        port_d = PORT_OFF;
      end
    endcase
  end

  // outputs
  always_comb begin
    led_o = port_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= LM_OFF;
      tick_q <= '0;
      pat_q  <= PATTERN_RST;
      port_q <= PORT_OFF;
    end else if (step_i) begin
      mode_q <= mode_d;
      tick_q <= tick_d;
      pat_q  <= pat_d;
      port_q <= port_d;
    end
  end

endmodule

@@ design/keypad_code_lock_top.sv @@
// keypad_code_lock_top: six-digit keypad lock, top level.
// Depends on kcl_pkg, kcl_if, kcl_apb_regs, kcl_entry and kcl_light.
//
// Usage:
//   in_i  carries one transaction per millisecond tick (opcode 0) or per
//         key scan sample (opcode 1, key_number 0 for none, 1..16 for S1..S16).
//   res_o returns exactly one transaction per input: LED port (active low),
//         lock status, change-mode flag, digit count, notice and refresh flag.
//   APB   holds flow_period at 0x0 and blink_period at 0x4 (16 bits each).
//         Write them only while no transaction is in flight.
// Timing:
//   An accepted transaction is held in the input register, where the
//   combinational entry/light update runs on it; the result register loads
//   the outcome when the transaction advances. One transaction per cycle
//   is sustained while res_o.ready stays high.
// Stalls:
//   If res_o.ready is low, the result register holds; the input register
//   still loads one more transaction, then in_i.ready drops until the result
//   is taken. Nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous): code 1-2-3-4-5-6, empty buffer, LEDs off
//   (0xFF), periods 200/300, both pipeline registers empty.
module keypad_code_lock_top import kcl_pkg::*; #(
  parameter int CODE_DIGITS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kcl_in_if.sink            in_i,
  kcl_out_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // input register
  logic      in_vld_q;
  kcl_item_t item_q;
  // result register
  logic             res_vld_q;
  logic [LED_W-1:0] led_q;
  kcl_status_t      stat_q;

  logic           adv;       // item moves from input to result register
  kcl_cfg_t       cfg;
  kcl_light_cmd_t light_cmd;
  kcl_status_t    stat;
  logic [LED_W-1:0] led;

  assign adv        = in_vld_q && (!res_vld_q || res_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.opcode     <= kcl_op_e'(in_i.opcode);
      item_q.key_number <= in_i.key_number;
    end
  end

  kcl_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kcl_entry #(.CODE_DIGITS(CODE_DIGITS)) u_entry (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .item_i   (item_q),
    .cmd_o    (light_cmd),
    .status_o (stat)
  );

  kcl_light u_light (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .tick_i (item_q.opcode == OP_TICK),
    .cmd_i  (light_cmd),
    .cfg_i  (cfg),
    .led_o  (led)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      led_q  <= led;
      stat_q <= stat;
    end
  end

  assign res_o.valid           = res_vld_q;
  assign res_o.led_port        = led_q;
  assign res_o.lock_status     = stat_q.phase;
  assign res_o.setting_active  = stat_q.change;
  assign res_o.digits_entered  = stat_q.digits;
  assign res_o.notice          = stat_q.notice;
  assign res_o.display_refresh = stat_q.refresh;

endmodule

@@ design/kcl_checker.sv @@
// kcl_checker: port-level assertions for keypad_code_lock_top, with its bind.
// Depends on kcl_pkg; attached to the top level by the bind below.
module kcl_checker import kcl_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic [LED_W-1:0] led_port_i,
  input logic [1:0]       lock_status_i,
  input logic             setting_active_i,
  input logic [2:0]       digits_entered_i,
  input logic [1:0]       notice_i,
  input logic             display_refresh_i
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(led_port_i)
      && $stable(lock_status_i) && $stable(notice_i) && $stable(digits_entered_i))
    else $error("result changed while stalled");

  // an empty result register never blocks the input
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  a_change_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && setting_active_i |-> lock_status_i == PH_OPEN)
    else $error("code change active while not unlocked");

  a_notice_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && notice_i != NT_NONE |-> display_refresh_i)
    else $error("notice without key edge");

  a_saved_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && notice_i == NT_SAVED |->
      lock_status_i == PH_ENTER && !setting_active_i && digits_entered_i == 3'd0)
    else $error("save left lock in wrong state");

endmodule

bind keypad_code_lock_top kcl_checker u_kcl_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_i        (in_i.ready),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .led_port_i        (res_o.led_port),
  .lock_status_i     (res_o.lock_status),
  .setting_active_i  (res_o.setting_active),
  .digits_entered_i  (res_o.digits_entered),
  .notice_i          (res_o.notice),
  .display_refresh_i (res_o.display_refresh)
);

@@ dv/tb.sv @@
// tb: self-checking bench for keypad_code_lock_top, a directed table then random key sessions.
// Depends on kcl_pkg and kcl_if. Results are checked against a predictor of the lock that lives
// inside the bench.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kcl_pkg::*;

  localparam int CODE_DIGITS = 6;

  typedef logic [CODE_DIGITS-1:0][DIGIT_W-1:0] code_t;

  // one result transaction, as seen on res_o
  typedef struct packed {
    logic [LED_W-1:0] led;
    kcl_phase_e       phase;
    logic             change;
    logic [2:0]       digits;
    kcl_notice_e      notice;
    logic             refresh;
  } lock_view_t;

  // a row of the directed table; want is used only when typed is set
  typedef struct packed {
    kcl_op_e          op;
    logic [KEY_W-1:0] key;
    logic             typed;
    lock_view_t       want;
  } dir_row_t;

  // periods and handshake behavior of one random phase
  typedef struct packed {
    logic [PERIOD_W-1:0] flow;
    logic [PERIOD_W-1:0] blink;
    int                  idle_pct;
    int                  stall_pct;
    int                  hold;
  } phase_plan_t;

  localparam lock_view_t IDLE_VIEW = '{PORT_OFF, PH_ENTER, 1'b0, 3'd0, NT_NONE, 1'b0};
  localparam int PHASE_ITEMS = 275;

  logic clk_i;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  kcl_in_if  in_if ();
  kcl_out_if res_if ();

  keypad_code_lock_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Directed table: reset state, refused change, an unused key, the factory code
  // with releases, a digit into a full buffer, unlock, change mode and clear.
  dir_row_t dir_rows [22] = '{
    '{OP_TICK, KEY_NONE,   1'b1, IDLE_VIEW},
    '{OP_SCAN, KEY_CHANGE, 1'b1, '{PORT_OFF, PH_ENTER, 1'b0, 3'd0, NT_REFUSED, 1'b1}},
    '{OP_SCAN, KEY_NONE,   1'b1, IDLE_VIEW},
    '{OP_SCAN, 5'd31,      1'b1, '{PORT_OFF, PH_ENTER, 1'b0, 3'd0, NT_NONE, 1'b1}},
    '{OP_SCAN, KEY_NONE,   1'b1, IDLE_VIEW},
    '{OP_SCAN, 5'd1,       1'b1, '{PORT_OFF, PH_ENTER, 1'b0, 3'd1, NT_NONE, 1'b1}},
    '{OP_SCAN, KEY_NONE,   1'b0, IDLE_VIEW},
    '{OP_SCAN, 5'd2,       1'b0, IDLE_VIEW},
    '{OP_SCAN, KEY_NONE,   1'b0, IDLE_VIEW},
    '{OP_SCAN, 5'd3,       1'b0, IDLE_VIEW},
    '{OP_SCAN, KEY_NONE,   1'b0, IDLE_VIEW},
    '{OP_SCAN, 5'd4,       1'b0, IDLE_VIEW},
    '{OP_SCAN, KEY_NONE,   1'b0, IDLE_VIEW},
    '{OP_SCAN, 5'd5,       1'b0, IDLE_VIEW},
    '{OP_SCAN, KEY_NONE,   1'b0, IDLE_VIEW},
    '{OP_SCAN, 5'd6,       1'b0, IDLE_VIEW},
    '{OP_SCAN, 5'd7,       1'b0, IDLE_VIEW},   // edge 1 with a full buffer: dropped
    '{OP_SCAN, KEY_NONE,   1'b0, IDLE_VIEW},
    '{OP_SCAN, KEY_CHECK,  1'b0, IDLE_VIEW},
    '{OP_SCAN, KEY_CHANGE, 1'b0, IDLE_VIEW},
    '{OP_SCAN, KEY_NONE,   1'b0, IDLE_VIEW},
    '{OP_SCAN, KEY_CLEAR,  1'b0, IDLE_VIEW}
  };

  // random phases: small periods step the lights often, zero steps them on every item
  phase_plan_t plan [6] = '{
    '{16'd3,           16'd5,            0,  0,  64},
    '{16'd1,           16'd2,            53, 0,  0},
    '{16'd7,           16'd4,            0,  53, 0},
    '{16'd0,           16'd0,            11, 11, 0},
    '{FLOW_PERIOD_RST, BLINK_PERIOD_RST, 0,  0,  0},
    '{16'd2,           16'd9,            11, 11, 0}
  };

  // predicted lock state
  code_t               code_q;
  code_t               entry_q;
  int                  n_digits;
  kcl_phase_e          phase_q;
  logic                changing;
  kcl_light_e          light_q;
  logic [PERIOD_W-1:0] tick_q;
  logic [LED_W-1:0]    pattern_q;
  logic [LED_W-1:0]    port_q;
  logic [KEY_W-1:0]    prev_key;
  logic [PERIOD_W-1:0] flow_per;
  logic [PERIOD_W-1:0] blink_per;

  lock_view_t views_due [$];

  int error_cnt;
  int results_seen;
  int offered;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_cnt++;
  endtask

  function automatic void reset_model();
    for (int i = 0; i < CODE_DIGITS; i++) code_q[i] = DIGIT_W'(i + 1);
    entry_q   = '0;
    n_digits  = 0;
    phase_q   = PH_ENTER;
    changing  = 1'b0;
    light_q   = LM_OFF;
    tick_q    = '0;
    pattern_q = PATTERN_RST;
    port_q    = PORT_OFF;
    prev_key  = KEY_NONE;
    flow_per  = FLOW_PERIOD_RST;
    blink_per = BLINK_PERIOD_RST;
  endfunction

  // Advance the lock by one input transaction and return the result it gives.
  function automatic lock_view_t step_lock(kcl_op_e op, logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] hit;
    kcl_notice_e      note;
    logic             refresh;
    lock_view_t       v;
    note    = NT_NONE;
    refresh = 1'b0;
    if (op == OP_TICK) begin
      if (tick_q != TICK_MAX) tick_q++;
    end else begin
      hit      = key & (prev_key ^ key);
      prev_key = key;
      if (hit != KEY_NONE) begin
        refresh = 1'b1;
        if (hit <= KEY_ZERO && n_digits < CODE_DIGITS) begin
          // first digit after a check restarts the entry
          if (!changing && phase_q != PH_ENTER) begin
            n_digits = 0;
            phase_q  = PH_ENTER;
          end
          entry_q[n_digits] = (hit == KEY_ZERO) ? '0 : hit[DIGIT_W-1:0];
          n_digits++;
        end else if (hit == KEY_CHECK) begin
          if (!changing && n_digits == CODE_DIGITS) begin
            if (entry_q == code_q) begin
              phase_q = PH_OPEN;
              light_q = LM_FLOW;
            end else begin
              phase_q = PH_WRONG;
              light_q = LM_BLINK;
            end
          end
        end else if (hit == KEY_CLEAR) begin
          n_digits = 0;
          phase_q  = PH_ENTER;
          changing = 1'b0;
          port_q   = port_q | LED_W'(1);
          light_q  = LM_OFF;
        end else if (hit == KEY_CHANGE) begin
          if (phase_q == PH_OPEN) begin
            if (!changing) begin
              changing = 1'b1;
              n_digits = 0;
            end else if (n_digits == CODE_DIGITS) begin
              code_q   = entry_q;
              changing = 1'b0;
              phase_q  = PH_ENTER;
              n_digits = 0;
              light_q  = LM_OFF;
              note     = NT_SAVED;
            end
          end else begin
            note = NT_REFUSED;
          end
        end
      end
    end
    case (light_q)
      LM_FLOW: begin
        if (tick_q >= flow_per) begin
          tick_q    = '0;
          pattern_q = {pattern_q[0], pattern_q[LED_W-1:1]};
          port_q    = pattern_q;
        end
      end
      LM_BLINK: begin
        if (tick_q >= blink_per) begin
          tick_q = '0;
          port_q = ~port_q;
        end
      end
      default: begin
        port_q = PORT_OFF;
        tick_q = '0;
      end
    endcase
    v.led     = port_q;
    v.phase   = phase_q;
    v.change  = changing;
    v.digits  = 3'(n_digits);
    v.notice  = note;
    v.refresh = refresh;
    return v;
  endfunction

  function automatic code_t random_code();
    code_t c;
    for (int i = 0; i < CODE_DIGITS; i++) c[i] = DIGIT_W'($urandom_range(9));
    return c;
  endfunction

  // Offer one input transaction, idling first at the phase's rate. Valid stays high
  // from one transaction to the next unless an idle cycle comes between them.
  task automatic offer(kcl_op_e op, logic [KEY_W-1:0] key, logic typed, lock_view_t want);
    lock_view_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid      <= 1'b0;
      in_if.opcode     <= 1'($urandom_range(1));
      in_if.key_number <= KEY_W'($urandom_range(31));
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.key_number <= key;
    do @(posedge clk_i); while (!in_if.ready);
    pred = step_lock(op, key);
    views_due.push_back(typed ? want : pred);
    offered++;
  endtask

  task automatic scan(logic [KEY_W-1:0] key);
    offer(OP_SCAN, key, 1'b0, IDLE_VIEW);
  endtask

  // the key number of a tick is don't-care, so it carries noise
  task automatic tick();
    offer(OP_TICK, KEY_W'($urandom_range(31)), 1'b0, IDLE_VIEW);
  endtask

  task automatic press(logic [KEY_W-1:0] key);
    scan(key);
    scan(KEY_NONE);
  endtask

  // more digits than the code holds wrap around to its first digits
  task automatic enter_digits(code_t d, int n);
    logic [DIGIT_W-1:0] dg;
    for (int i = 0; i < n; i++) begin
      dg = d[i % CODE_DIGITS];
      press((dg == '0) ? KEY_ZERO : KEY_W'(dg));
    end
  endtask

  // mostly short bursts; now and then long enough for a few light steps
  task automatic tick_burst();
    int n;
    int per;
    per = (flow_per > blink_per) ? int'(flow_per) : int'(blink_per);
    if ($urandom_range(9) == 0) n = $urandom_range(2 * per + 2);
    else n = $urandom_range(12);
    if (n > 800) n = 800;
    repeat (n) tick();
  endtask

  task automatic random_session();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      // right code, unlock, and often a code change
      if ($urandom_range(9) < 7) press(KEY_CLEAR);
      enter_digits(code_q, CODE_DIGITS);
      press(KEY_CHECK);
      tick_burst();
      if ($urandom_range(1) == 1) begin
        press(KEY_CHANGE);
        enter_digits(random_code(),
                     ($urandom_range(9) == 0) ? $urandom_range(CODE_DIGITS) : CODE_DIGITS);
        press(KEY_CHANGE);
        tick_burst();
      end
    end else if (pick < 60) begin
      // guessed code, sometimes short or one digit too many
      if ($urandom_range(9) < 7) press(KEY_CLEAR);
      enter_digits(random_code(),
                   ($urandom_range(4) == 0) ? $urandom_range(CODE_DIGITS + 1) : CODE_DIGITS);
      press(KEY_CHECK);
      tick_burst();
    end else if (pick < 68) begin
      press(KEY_CLEAR);
    end else if (pick < 76) begin
      press(KEY_CHANGE);
    end else if (pick < 84) begin
      tick_burst();
    end else begin
      // raw scans without releases, so edges come from overlapping key numbers
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(3) == 0) tick();
        else scan(KEY_W'($urandom_range(31)));
      end
    end
  endtask

  // APB write, then a read back of the same register. Caller arrives right after an edge.
  task automatic write_reg(kcl_reg_e r, logic [PERIOD_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= APB_DW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (r == REG_FLOW) flow_per = val;
    else blink_per = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[PERIOD_W-1:0] != val)
      report_mismatch($sformatf("register %s reads %h, written %h", r.name(),
                                prdata[PERIOD_W-1:0], val));
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Registers change only with nothing in flight; one result per item, so an
  // empty queue plus the pipeline depth is enough.
  task automatic set_periods(logic [PERIOD_W-1:0] f, logic [PERIOD_W-1:0] b);
    while (views_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_reg(REG_FLOW, f);
    write_reg(REG_BLINK, b);
  endtask

  task automatic check_result();
    lock_view_t want;
    results_seen++;
    if (views_due.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with no transaction outstanding",
                                results_seen));
    end else begin
      want = views_due.pop_front();
      if (res_if.led_port != want.led)
        report_mismatch($sformatf("result %0d led_port %h, expected %h",
                                  results_seen, res_if.led_port, want.led));
      if (res_if.lock_status != want.phase)
        report_mismatch($sformatf("result %0d lock_status %0d, expected %0d",
                                  results_seen, res_if.lock_status, want.phase));
      if (res_if.setting_active != want.change)
        report_mismatch($sformatf("result %0d setting_active %0d, expected %0d",
                                  results_seen, res_if.setting_active, want.change));
      if (res_if.digits_entered != want.digits)
        report_mismatch($sformatf("result %0d digits_entered %0d, expected %0d",
                                  results_seen, res_if.digits_entered, want.digits));
      if (res_if.notice != want.notice)
        report_mismatch($sformatf("result %0d notice %0d, expected %0d",
                                  results_seen, res_if.notice, want.notice));
      if (res_if.display_refresh != want.refresh)
        report_mismatch($sformatf("result %0d display_refresh %0d, expected %0d",
                                  results_seen, res_if.display_refresh, want.refresh));
    end
  endtask

  // Result side: check at the edge, then choose ready for the next cycle.
  // A pending hold keeps ready low so the pipeline fills and in_i.ready drops.
  initial begin : result_sink
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) check_result();
      if (hold_cycles > 0) begin
        res_if.ready <= 1'b0;
        hold_cycles--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    code_t wrong;
    int    start;
    error_cnt      = 0;
    results_seen   = 0;
    offered        = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    reset_model();
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.opcode     <= OP_TICK;
    in_if.key_number <= KEY_NONE;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      offer(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);
    in_if.valid <= 1'b0;

    foreach (plan[p]) begin
      set_periods(plan[p].flow, plan[p].blink);
      send_idle_pct  = plan[p].idle_pct;
      recv_stall_pct = plan[p].stall_pct;
      hold_cycles    = plan[p].hold;
      start          = offered;
      while (offered - start < PHASE_ITEMS) random_session();
      in_if.valid <= 1'b0;
    end

    // Widest periods: a run of ticks in each light mode steps nothing.
    set_periods(TICK_MAX, TICK_MAX);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    press(KEY_CLEAR);
    enter_digits(code_q, CODE_DIGITS);
    press(KEY_CHECK);
    repeat (40) tick();
    press(KEY_CLEAR);
    wrong    = code_q;
    wrong[0] = (code_q[0] == DIGIT_W'(9)) ? '0 : code_q[0] + DIGIT_W'(1);
    enter_digits(wrong, CODE_DIGITS);
    press(KEY_CHECK);
    repeat (40) tick();
    in_if.valid <= 1'b0;

    // drain, then let any stray transaction show up
    recv_stall_pct = 0;
    while (views_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/kcl_pkg.sv
design/kcl_if.sv
design/kcl_apb_regs.sv
design/kcl_entry.sv
design/kcl_light.sv
design/keypad_code_lock_top.sv
design/kcl_checker.sv
dv/tb.sv
